>>> src/twg_pkg.sv
// twg_pkg: shared constants, codes and types for the tone waveform generator
// used by twg_arith and tone_waveform_generator; depends on nothing else
package twg_pkg;

    // field and register widths
    localparam int PEAK_W    = 12;
    localparam int TONE_W    = 15;
    localparam int SAMPLE_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int PERIOD_W  = 16;

    // reset values of the configuration registers
    localparam logic [PEAK_W-1:0] PEAK_RESET = PEAK_W'(100);
    localparam logic [TONE_W-1:0] TONE_RESET = TONE_W'(250);

    // timing constants
    localparam int TIMEOUT_TICKS = 44165;
    localparam int SQUARE_RATE   = 41000;

    // time constant K in Q0.32, rounded products keep the bits above ROUND_SHIFT
    localparam int               K_W         = 17;
    localparam logic [K_W-1:0]   K_Q32       = K_W'(97250);
    localparam int               K_IDX_W     = $clog2(K_W);
    localparam int               ROUND_SHIFT = 32;

    // multiplier operand is peak * tone, doubled for the triangle
    localparam int MUL_X_W = PEAK_W + TONE_W + 1;
    localparam int ACC_W   = MUL_X_W + K_W + 1;
    localparam int STEP_W  = ACC_W - ROUND_SHIFT;

    // square period divider: (2*rate + f) / (2*f)
    localparam int DIVISOR_W  = TONE_W + 1;
    localparam int REM_W      = DIVISOR_W + 1;
    localparam int DIVIDEND_W = $clog2(2 * SQUARE_RATE + 2 ** TONE_W);

    // iteration counter of the shared unit
    localparam int ITER_MAX = (K_W > DIVIDEND_W) ? K_W : DIVIDEND_W;
    localparam int CNT_W    = $clog2(ITER_MAX);

    // configuration port
    localparam int                   CFG_IDX_W  = 1;
    localparam int                   CFG_DATA_W = TONE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE   = 1'b1;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_TRI    = 2'd1,
        MODE_SAW    = 2'd2,
        MODE_SQUARE = 2'd3
    } wave_t;

    typedef enum logic {
        AOP_MUL = 1'b0,
        AOP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_PUSH = 3'b100
    } state_t;

endpackage

>>> src/twg_arith.sv
// twg_arith: shared shift-add / shift-subtract unit, one bit per cycle
// rounds x*K to Q0 or divides for the square period; depends on twg_pkg
module twg_arith
    import twg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  arith_req_t            req,
    input  logic [MUL_X_W-1:0]    mul_x,
    input  logic [DIVIDEND_W-1:0] div_n,
    input  logic [DIVISOR_W-1:0]  div_d,
    output arith_rsp_t            rsp,
    output logic [PERIOD_W-1:0]   result
);

    arith_op_t        op_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] mcand_reg;

    arith_op_t        op_next;
    logic             busy_next;
    logic             done_next;
    logic [CNT_W-1:0] cnt_next;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] mcand_next;

    logic [REM_W-1:0]      rem;
    logic [DIVIDEND_W-1:0] quot;
    logic [REM_W-1:0]      shifted;
    logic [ACC_W-1:0]      add_a;
    logic [ACC_W-1:0]      add_b;
    logic                  add_cin;
    logic [ACC_W-1:0]      sum;
    logic                  ge;
    logic                  last;
    logic                  k_bit;

    // divider view of the accumulator: remainder above, dividend/quotient below
    assign rem     = acc_reg[DIVIDEND_W +: REM_W];
    assign quot    = acc_reg[DIVIDEND_W-1:0];
    assign shifted = {rem[REM_W-2:0], quot[DIVIDEND_W-1]};
    assign k_bit   = K_Q32[cnt_reg[K_IDX_W-1:0]];

    // the one adder, shared by both operations
    always_comb
    begin
        if (op_reg == AOP_MUL)
        begin
            add_a   = acc_reg;
            add_b   = mcand_reg;
            add_cin = 1'b0;
        end
        else
        begin
            add_a   = ACC_W'(shifted);
            add_b   = ~ACC_W'(div_d);
            add_cin = 1'b1;
        end
        sum = add_a + add_b + ACC_W'(add_cin);
    end

    assign ge   = ~sum[ACC_W-1];
    assign last = (op_reg == AOP_MUL) ? (cnt_reg == CNT_W'(K_W - 1))
                                      : (cnt_reg == CNT_W'(DIVIDEND_W - 1));

    // sequencer
    always_comb
    begin
        op_next    = op_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        if (req.start)
        begin
            op_next   = req.op;
            busy_next = 1'b1;
            cnt_next  = '0;
            if (req.op == AOP_MUL)
            begin
                // rounding half preloaded into the accumulator
                acc_next   = ACC_W'(1) << (ROUND_SHIFT - 1);
                mcand_next = ACC_W'(mul_x);
            end
            else
            begin
                acc_next = ACC_W'(div_n);
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (op_reg == AOP_MUL)
            begin
                if (k_bit)
                begin
                    acc_next = sum;
                end
                mcand_next = mcand_reg << 1;
            end
            else
            begin
                acc_next = ACC_W'({(ge ? sum[REM_W-1:0] : shifted),
                                   quot[DIVIDEND_W-2:0], ge});
            end
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= AOP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = (op_reg == AOP_MUL) ? PERIOD_W'(acc_reg[ACC_W-1:ROUND_SHIFT])
                                          : acc_reg[PERIOD_W-1:0];

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("arith unit started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("arith done without a running operation");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("arith busy and done together");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && op_reg == AOP_MUL) |-> cnt_reg <= CNT_W'(K_W - 1))
        else $error("multiply ran past the constant width");

endmodule

>>> src/tone_waveform_generator.sv
// tone_waveform_generator: top level of the per-sample tone generator
// holds mode, waveform state and handshakes; depends on twg_pkg and twg_arith
//
// Each tick transaction yields one DAC sample for the current mode (off, triangle,
// sawtooth, square); a start transaction selects the mode and returns the held
// sample. A start or a tick while off goes straight from acceptance to the push
// state, which loads the output register. A tick in triangle, sawtooth or square
// mode first runs the calculation state: the step and the square period come from
// one shared shift-add / shift-subtract unit that handles one bit per cycle (17
// multiplier bits of K, 17 quotient bits); its registered done flag ends the
// calculation, which updates the waveform state, and the push state then loads the
// output register. A stalled output holds the push state while the result register
// stays full. Items are taken one at a time; the next may be accepted while the
// previous result still waits at the output register. Configuration writes are
// taken every cycle.
module tone_waveform_generator
    import twg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  opcode,
    input  logic [1:0]            wave_select,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [SAMPLE_W-1:0]   dac_sample,
    output logic [1:0]            active_wave,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t               state_reg,        state_next;
    logic [PEAK_W-1:0]    peak_reg,         peak_next;
    logic [TONE_W-1:0]    tone_reg,         tone_next;
    wave_t                mode_reg,         mode_next;
    wave_t                wave_reg,         wave_next;
    logic [ELAPSED_W-1:0] elapsed_reg,      elapsed_next;
    logic [SAMPLE_W-1:0]  tri_level_reg,    tri_level_next;
    logic                 tri_up_reg,       tri_up_next;
    logic [SAMPLE_W-1:0]  saw_level_reg,    saw_level_next;
    logic                 sq_phase_reg,     sq_phase_next;
    logic [SAMPLE_W-1:0]  sq_counter_reg,   sq_counter_next;
    logic [SAMPLE_W-1:0]  held_reg,         held_next;
    logic                 result_valid_reg, result_valid_next;
    logic [SAMPLE_W-1:0]  dac_sample_reg,   dac_sample_next;
    wave_t                active_wave_reg,  active_wave_next;

    logic                          accept;
    logic [TONE_W-1:0]             tone_nz;
    logic [PEAK_W+TONE_W-1:0]      peak_tone;
    logic [ELAPSED_W-1:0]          elapsed_inc;
    arith_req_t                    arith_req;
    arith_rsp_t                    arith_rsp;
    logic [MUL_X_W-1:0]            mul_x;
    logic [DIVIDEND_W-1:0]         div_n;
    logic [DIVISOR_W-1:0]          div_d;
    logic [PERIOD_W-1:0]           arith_result;
    logic [SAMPLE_W-1:0]           step;
    logic [SAMPLE_W-1:0]           peak_ext;
    logic                          tri_up_w;
    logic [SAMPLE_W-1:0]           saw_base;
    logic [SAMPLE_W:0]             sq_count_inc;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;

    // operands for the shared unit, a zero tone counts as one in the divider
    assign tone_nz   = (tone_reg == '0) ? TONE_W'(1) : tone_reg;
    assign peak_tone = {{TONE_W{1'b0}}, peak_reg} * {{PEAK_W{1'b0}}, tone_reg};
    assign mul_x     = (mode_reg == MODE_TRI) ? {peak_tone, 1'b0} : {1'b0, peak_tone};
    assign div_n     = DIVIDEND_W'(2 * SQUARE_RATE) + DIVIDEND_W'(tone_nz);
    assign div_d     = {tone_nz, 1'b0};

    assign arith_req.start = accept && (opcode == OP_TICK) && (mode_reg != MODE_OFF);
    assign arith_req.op    = (mode_reg == MODE_SQUARE) ? AOP_DIV : AOP_MUL;

    twg_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (arith_req),
        .mul_x  (mul_x),
        .div_n  (div_n),
        .div_d  (div_d),
        .rsp    (arith_rsp),
        .result (arith_result)
    );

    // waveform step helpers
    assign step         = SAMPLE_W'(arith_result[STEP_W-1:0]);
    assign peak_ext     = SAMPLE_W'(peak_reg);
    assign tri_up_w     = tri_up_reg && !(tri_level_reg > peak_ext);
    assign saw_base     = (saw_level_reg > peak_ext) ? '0 : saw_level_reg;
    assign sq_count_inc = {1'b0, sq_counter_reg} + (SAMPLE_W + 1)'(1);
    assign elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + ELAPSED_W'(1);

    // sequencer and state update
    always_comb
    begin
        state_next        = state_reg;
        peak_next         = peak_reg;
        tone_next         = tone_reg;
        mode_next         = mode_reg;
        wave_next         = wave_reg;
        elapsed_next      = elapsed_reg;
        tri_level_next    = tri_level_reg;
        tri_up_next       = tri_up_reg;
        saw_level_next    = saw_level_reg;
        sq_phase_next     = sq_phase_reg;
        sq_counter_next   = sq_counter_reg;
        held_next         = held_reg;
        result_valid_next = result_valid_reg;
        dac_sample_next   = dac_sample_reg;
        active_wave_next  = active_wave_reg;

        // configuration writes
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PEAK: peak_next = cfg_data[PEAK_W-1:0];
                CFG_TONE: tone_next = cfg_data[TONE_W-1:0];
                default:  ;
            endcase
        end

        // result taken downstream
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_START)
                    begin
                        mode_next    = wave_t'(wave_select);
                        elapsed_next = '0;
                        state_next   = S_PUSH;
                    end
                    else if (mode_reg == MODE_OFF)
                    begin
                        elapsed_next = '0;
                        held_next    = '0;
                        state_next   = S_PUSH;
                    end
                    else
                    begin
                        // timeout falls back to off, this tick still plays
                        wave_next    = mode_reg;
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= ELAPSED_W'(TIMEOUT_TICKS))
                        begin
                            elapsed_next = '0;
                            mode_next    = MODE_OFF;
                        end
                        state_next = S_CALC;
                    end
                end
            end

            S_CALC:
            begin
                if (arith_rsp.done)
                begin
                    case (wave_reg)
                        MODE_TRI:
                        begin
                            tri_up_next = tri_up_w;
                            if (tri_up_w)
                            begin
                                tri_level_next = tri_level_reg + step;
                            end
                            else if (tri_level_reg < step)
                            begin
                                tri_up_next = 1'b1;
                            end
                            else
                            begin
                                tri_level_next = tri_level_reg - step;
                            end
                            held_next = tri_up_w ? tri_level_reg + step :
                                        (tri_level_reg < step) ? tri_level_reg :
                                        tri_level_reg - step;
                        end
                        MODE_SAW:
                        begin
                            saw_level_next = saw_base + step;
                            held_next      = saw_base + step;
                        end
                        MODE_SQUARE:
                        begin
                            if (sq_count_inc > {1'b0, arith_result})
                            begin
                                sq_counter_next = '0;
                                sq_phase_next   = !sq_phase_reg;
                                held_next       = !sq_phase_reg ? peak_ext : '0;
                            end
                            else
                            begin
                                sq_counter_next = sq_count_inc[SAMPLE_W-1:0];
                            end
                        end
                        default: ;
                    endcase
                    state_next = S_PUSH;
                end
            end

            S_PUSH:
            begin
                // output register free or being emptied this cycle
                if (!result_valid_reg || !result_stall)
                begin
                    dac_sample_next   = held_reg;
                    active_wave_next  = mode_reg;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and waveform state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            peak_reg         <= PEAK_RESET;
            tone_reg         <= TONE_RESET;
            mode_reg         <= MODE_OFF;
            wave_reg         <= MODE_OFF;
            elapsed_reg      <= '0;
            tri_level_reg    <= '0;
            tri_up_reg       <= 1'b1;
            saw_level_reg    <= '0;
            sq_phase_reg     <= 1'b0;
            sq_counter_reg   <= '0;
            held_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            peak_reg         <= peak_next;
            tone_reg         <= tone_next;
            mode_reg         <= mode_next;
            wave_reg         <= wave_next;
            elapsed_reg      <= elapsed_next;
            tri_level_reg    <= tri_level_next;
            tri_up_reg       <= tri_up_next;
            saw_level_reg    <= saw_level_next;
            sq_phase_reg     <= sq_phase_next;
            sq_counter_reg   <= sq_counter_next;
            held_reg         <= held_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        dac_sample_reg  <= dac_sample_next;
        active_wave_reg <= active_wave_next;
    end

    assign result_valid = result_valid_reg;
    assign dac_sample   = dac_sample_reg;
    assign active_wave  = active_wave_reg;

    // checks
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        arith_rsp.done |-> state_reg == S_CALC)
        else $error("arith result arrived outside calculation");

    a_off_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OFF) |-> elapsed_reg == '0)
        else $error("elapsed counter running while off");

    a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_PUSH)
        else $error("result raised outside push state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction left no work");

endmodule
